>>> sv/tlhp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlhp_pkg
// Shared types, codes and defaults of the two-level handle pool.
// ----------------------------------------------------------------------------
package tlhp_pkg;

  localparam int NUM_CLIENTS_DEF   = 8;
  localparam int PRIVATE_DEPTH_DEF = 8;
  localparam int GLOBAL_DEPTH_DEF  = 2048;
  localparam int HANDLE_BITS_DEF   = 16;

  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 12;

  localparam logic [3:0]  PRIVATE_LIMIT_RST    = 4'd7;
  localparam logic [2:0]  KEEP_AFTER_SPILL_RST = 3'd4;
  localparam logic [11:0] GLOBAL_LIMIT_RST     = 12'(2048 - 3);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_PRIVATE_LIMIT    = 2'd0,
    CFG_KEEP_AFTER_SPILL = 2'd1,
    CFG_GLOBAL_LIMIT     = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    OP_TAKE = 1'b0,
    OP_PUT  = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    SRC_PRIVATE = 2'd0,
    SRC_GLOBAL  = 2'd1,
    SRC_FRESH   = 2'd2
  } take_src_t;

  typedef struct packed {
    logic [3:0]  private_limit;
    logic [2:0]  keep_after_spill;
    logic [11:0] global_limit;
  } tlhp_cfg_t;

  // wrap a raw client number into 0..n-1
  function automatic logic [6:0] wrap_client(input logic [2:0] raw, input logic [6:0] n);
    logic [6:0] v;
    v = {4'd0, raw};
    for (int i = 0; i < 8; i++) begin
      if (v >= n) begin
        v = v - n;
      end
    end
    return v;
  endfunction

endpackage

>>> sv/tlhp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlhp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tlhp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> sv/tlhp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlhp_ctrl
// Sequencer of the handle pool: moves one handle per step between the
// private stacks and the global stack, all held in RAM.
// ----------------------------------------------------------------------------
module tlhp_ctrl import tlhp_pkg::*; #(
  parameter int NUM_CLIENTS   = NUM_CLIENTS_DEF,
  parameter int PRIVATE_DEPTH = PRIVATE_DEPTH_DEF,
  parameter int GLOBAL_DEPTH  = GLOBAL_DEPTH_DEF,
  parameter int HANDLE_BITS   = HANDLE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_opcode,
  input  logic [2:0]  in_client,
  input  logic [15:0] in_handle_in,
  input  tlhp_cfg_t   cfg,
  output logic        out_valid,
  output logic [15:0] out_handle_out,
  output logic [1:0]  out_take_source,
  output logic        out_release_valid,
  output logic [15:0] out_release_handle,
  output logic [11:0] out_global_level
);

  localparam int CIW = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1;
  localparam int PIW = $clog2(PRIVATE_DEPTH);
  localparam int CW  = $clog2(PRIVATE_DEPTH + 1);
  localparam int GCW = $clog2(GLOBAL_DEPTH + 1);
  localparam int GAW = $clog2(GLOBAL_DEPTH);
  localparam int NCS = 1 << CIW;
  localparam int HB  = HANDLE_BITS;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_COUNT  = 7'b0000010,
    ST_TAKE_P = 7'b0000100,
    ST_TAKE_G = 7'b0001000,
    ST_SPILL  = 7'b0010000,
    ST_MOVE   = 7'b0100000,
    ST_EVICT  = 7'b1000000
  } state_t;

  state_t         state_r, state_nxt;
  logic           op_r, op_nxt;
  logic [CIW-1:0] c_r, c_nxt;
  logic [HB-1:0]  h_r, h_nxt;
  logic [CW-1:0]  pc_r, pc_nxt;
  logic [GCW-1:0] gc_r, gc_nxt;
  logic [NCS-1:0] valid_r, valid_nxt;

  logic           out_valid_r, out_valid_nxt;
  logic [15:0]    out_handle_r, out_handle_nxt;
  logic [1:0]     out_src_r, out_src_nxt;
  logic           out_rel_r, out_rel_nxt;
  logic [15:0]    out_rel_h_r, out_rel_h_nxt;
  logic [11:0]    out_level_r, out_level_nxt;

  logic [CIW-1:0] c_in;
  logic [CW-1:0]  plim;
  logic [GCW-1:0] glim;
  logic [CW-1:0]  pc_cur;
  logic           can_move;

  logic               p_we;
  logic [CIW+PIW-1:0] p_waddr, p_raddr;
  logic [HB-1:0]      p_wdata, p_rdata;
  logic               g_we;
  logic [GAW-1:0]     g_waddr, g_raddr;
  logic [HB-1:0]      g_wdata, g_rdata;
  logic               k_we;
  logic [CW-1:0]      k_wdata, k_rdata;

  logic               push;
  logic [CW-1:0]      push_pos;
  logic               done;
  logic [HB-1:0]      res_handle;
  take_src_t          res_src;
  logic               res_rel;
  logic [HB-1:0]      res_rel_h;

  assign c_in = CIW'(wrap_client(in_client, 7'(NUM_CLIENTS)));

  always_comb begin
    if (cfg.private_limit == 4'd0) begin
      plim = CW'(1);
    end else if (32'(cfg.private_limit) > PRIVATE_DEPTH) begin
      plim = CW'(PRIVATE_DEPTH);
    end else begin
      plim = CW'(cfg.private_limit);
    end
    if (32'(cfg.global_limit) > GLOBAL_DEPTH) begin
      glim = GCW'(GLOBAL_DEPTH);
    end else begin
      glim = GCW'(cfg.global_limit);
    end
  end

  assign pc_cur   = valid_r[c_r] ? k_rdata : '0;
  assign can_move = (32'(pc_r) > 32'(cfg.keep_after_spill)) && (gc_r < glim);
  assign busy     = (state_r != ST_IDLE);

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    c_nxt      = c_r;
    h_nxt      = h_r;
    pc_nxt     = pc_r;
    gc_nxt     = gc_r;
    valid_nxt  = valid_r;
    p_we       = 1'b0;
    p_waddr    = {c_r, PIW'(pc_r)};
    p_wdata    = h_r;
    p_raddr    = {c_r, PIW'(pc_r - CW'(1))};
    g_we       = 1'b0;
    g_waddr    = GAW'(gc_r);
    g_wdata    = p_rdata;
    g_raddr    = GAW'(gc_r - GCW'(1));
    k_we       = 1'b0;
    k_wdata    = pc_r;
    push       = 1'b0;
    push_pos   = pc_r;
    done       = 1'b0;
    res_handle = '0;
    res_src    = SRC_PRIVATE;
    res_rel    = 1'b0;
    res_rel_h  = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          op_nxt    = in_opcode;
          c_nxt     = c_in;
          h_nxt     = HB'(in_handle_in);
          state_nxt = ST_COUNT;
        end
      end
      ST_COUNT: begin
        if (op_r == OP_TAKE) begin
          if (pc_cur != '0) begin
            pc_nxt    = pc_cur - CW'(1);
            p_raddr   = {c_r, PIW'(pc_cur - CW'(1))};
            state_nxt = ST_TAKE_P;
          end else if (gc_r != '0) begin
            gc_nxt    = gc_r - GCW'(1);
            state_nxt = ST_TAKE_G;
          end else begin
            done      = 1'b1;
            res_src   = SRC_FRESH;
            state_nxt = ST_IDLE;
          end
        end else if (pc_cur >= plim) begin
          pc_nxt    = pc_cur;
          state_nxt = ST_SPILL;
        end else begin
          push     = 1'b1;
          push_pos = pc_cur;
        end
      end
      ST_TAKE_P: begin
        done       = 1'b1;
        res_handle = p_rdata;
        k_we       = 1'b1;
        k_wdata    = pc_r;
        state_nxt  = ST_IDLE;
      end
      ST_TAKE_G: begin
        done       = 1'b1;
        res_handle = g_rdata;
        res_src    = SRC_GLOBAL;
        state_nxt  = ST_IDLE;
      end
      ST_SPILL: begin
        if (can_move) begin
          pc_nxt    = pc_r - CW'(1);
          state_nxt = ST_MOVE;
        end else if (pc_r >= plim) begin
          state_nxt = ST_EVICT;
        end else begin
          push     = 1'b1;
          push_pos = pc_r;
        end
      end
      ST_MOVE: begin
        g_we      = 1'b1;
        gc_nxt    = gc_r + GCW'(1);
        state_nxt = ST_SPILL;
      end
      ST_EVICT: begin
        res_rel   = 1'b1;
        res_rel_h = p_rdata;
        push      = 1'b1;
        push_pos  = plim - CW'(1);
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (push) begin
      p_we      = 1'b1;
      p_waddr   = {c_r, PIW'(push_pos)};
      k_we      = 1'b1;
      k_wdata   = push_pos + CW'(1);
      done      = 1'b1;
      state_nxt = ST_IDLE;
    end
    if (k_we) begin
      valid_nxt[c_r] = 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt  = done;
    out_handle_nxt = out_handle_r;
    out_src_nxt    = out_src_r;
    out_rel_nxt    = out_rel_r;
    out_rel_h_nxt  = out_rel_h_r;
    out_level_nxt  = out_level_r;
    if (done) begin
      out_handle_nxt = 16'(res_handle);
      out_src_nxt    = res_src;
      out_rel_nxt    = res_rel;
      out_rel_h_nxt  = 16'(res_rel_h);
      out_level_nxt  = 12'(gc_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      gc_r        <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      gc_r        <= gc_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    c_r          <= c_nxt;
    h_r          <= h_nxt;
    pc_r         <= pc_nxt;
    out_handle_r <= out_handle_nxt;
    out_src_r    <= out_src_nxt;
    out_rel_r    <= out_rel_nxt;
    out_rel_h_r  <= out_rel_h_nxt;
    out_level_r  <= out_level_nxt;
  end

  tlhp_ram #(
    .WIDTH (HB),
    .DEPTH (1 << (CIW + PIW))
  ) u_private_ram (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (p_wdata),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  tlhp_ram #(
    .WIDTH (HB),
    .DEPTH (GLOBAL_DEPTH)
  ) u_global_ram (
    .clk   (clk),
    .we    (g_we),
    .waddr (g_waddr),
    .wdata (g_wdata),
    .raddr (g_raddr),
    .rdata (g_rdata)
  );

  tlhp_ram #(
    .WIDTH (CW),
    .DEPTH (NCS)
  ) u_count_ram (
    .clk   (clk),
    .we    (k_we),
    .waddr (c_r),
    .wdata (k_wdata),
    .raddr (c_in),
    .rdata (k_rdata)
  );

  assign out_valid          = out_valid_r;
  assign out_handle_out     = out_handle_r;
  assign out_take_source    = out_src_r;
  assign out_release_valid  = out_rel_r;
  assign out_release_handle = out_rel_h_r;
  assign out_global_level   = out_level_r;

endmodule

>>> sv/two_level_handle_pool.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_level_handle_pool
// Pool of free buffer handles: per-client private stacks over one shared
// global stack, with spill, evict and allocate-fresh reporting.
//
//   channel  handshake            payload
//   -------  -------------------  ---------------------------------------
//   input    start & !busy        in_opcode, in_client, in_handle_in
//   result   out_valid (1 cycle)  out_handle_out, out_take_source,
//                                 out_release_valid, out_release_handle,
//                                 out_global_level
//   config   cfg_we               cfg_index, cfg_wdata
//
// A put may spill handles to the global stack: every handle spilled
// costs one private RAM read and one global RAM write in two steps of
// the sequencer. The registered result strobe rises as busy falls.
// Synchronous reset empties every stack at once; no clearing pass.
// Results are never held back; out_valid is a single-cycle strobe.
// ----------------------------------------------------------------------------
module two_level_handle_pool import tlhp_pkg::*; #(
  parameter int NUM_CLIENTS   = NUM_CLIENTS_DEF,
  parameter int PRIVATE_DEPTH = PRIVATE_DEPTH_DEF,
  parameter int GLOBAL_DEPTH  = GLOBAL_DEPTH_DEF,
  parameter int HANDLE_BITS   = HANDLE_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic                     in_opcode,
  input  logic [2:0]               in_client,
  input  logic [15:0]              in_handle_in,
  output logic                     out_valid,
  output logic [15:0]              out_handle_out,
  output logic [1:0]               out_take_source,
  output logic                     out_release_valid,
  output logic [15:0]              out_release_handle,
  output logic [11:0]              out_global_level,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

  tlhp_cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_PRIVATE_LIMIT:    cfg_nxt.private_limit    = cfg_wdata[3:0];
        CFG_KEEP_AFTER_SPILL: cfg_nxt.keep_after_spill = cfg_wdata[2:0];
        CFG_GLOBAL_LIMIT:     cfg_nxt.global_limit     = cfg_wdata[11:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.private_limit    <= PRIVATE_LIMIT_RST;
      cfg_r.keep_after_spill <= KEEP_AFTER_SPILL_RST;
      cfg_r.global_limit     <= GLOBAL_LIMIT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  tlhp_ctrl #(
    .NUM_CLIENTS   (NUM_CLIENTS),
    .PRIVATE_DEPTH (PRIVATE_DEPTH),
    .GLOBAL_DEPTH  (GLOBAL_DEPTH),
    .HANDLE_BITS   (HANDLE_BITS)
  ) u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_opcode          (in_opcode),
    .in_client          (in_client),
    .in_handle_in       (in_handle_in),
    .cfg                (cfg_r),
    .out_valid          (out_valid),
    .out_handle_out     (out_handle_out),
    .out_take_source    (out_take_source),
    .out_release_valid  (out_release_valid),
    .out_release_handle (out_release_handle),
    .out_global_level   (out_global_level)
  );

endmodule
